[design/htfd_pkg.sv]
// shared types, constants and functions of the humidity/temperature frame decoder
// no dependencies; imported by every module of the block
package htfd_pkg;

  // byte positions within the six-byte reply
  localparam logic [2:0] POS_TEMP_MSB = 3'd0;
  localparam logic [2:0] POS_TEMP_LSB = 3'd1;
  localparam logic [2:0] POS_TEMP_CRC = 3'd2;
  localparam logic [2:0] POS_HUM_MSB  = 3'd3;
  localparam logic [2:0] POS_HUM_LSB  = 3'd4;
  localparam logic [2:0] POS_HUM_CRC  = 3'd5;

  // crc-8 settings
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // conversion scales, offset and the word full-scale divisor
  localparam logic [14:0]        TEMP_SCALE  = 15'd17500;
  localparam logic [13:0]        HUM_SCALE   = 14'd10000;
  localparam logic signed [15:0] TEMP_OFFSET = -16'sd4500;
  localparam logic [16:0]        WORD_FULL   = 17'd65535;

  // one received byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } byte_item_t;

  // one decoded measurement
  typedef struct packed {
    logic signed [14:0] temperature_centi;
    logic [13:0]        humidity_centi;
    logic [15:0]        temperature_word;
    logic [15:0]        humidity_word;
    logic               temperature_crc_ok;
    logic               humidity_crc_ok;
  } result_item_t;

  // complete frame handed from the byte tracker to the converter
  typedef struct packed {
    logic [15:0] temperature_word;
    logic [15:0] humidity_word;
    logic        temperature_crc_ok;
    logic        humidity_crc_ok;
  } frame_t;

  // crc-8 update over one byte, msb first, no final xor
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // floor(x / 65535) for x below 2^31: x/65536 plus one correction step
  function automatic logic [15:0] div_word_full(input logic [31:0] x);
    logic [15:0] q0;
    logic [16:0] r0;
    q0 = x[31:16];
    r0 = {1'b0, x[15:0]} + {1'b0, q0};
    return (r0 >= WORD_FULL) ? (q0 + 16'd1) : q0;
  endfunction

endpackage

[design/htfd_frame_track.sv]
// byte position tracking, running crc-8 and word assembly of one reply
// depends on htfd_pkg; holds one completed frame until the converter takes it
module htfd_frame_track
  import htfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_take,
  input  byte_item_t byte_in,
  input  logic       frame_pop,
  output logic       frame_valid,
  output frame_t     frame
);

  logic [2:0]  position;
  logic [2:0]  pos_eff;
  logic [2:0]  position_next;
  logic [7:0]  running_crc;
  logic [7:0]  crc_step;
  logic [7:0]  high_hold;
  logic [7:0]  low_hold;
  logic [15:0] temp_hold;
  logic        temp_ok_hold;
  logic        frame_done;

  // frame start or a stray position restarts the reply
  always_comb begin
    pos_eff = position;
    if (byte_in.frame_start || (position > POS_HUM_CRC)) begin
      pos_eff = POS_TEMP_MSB;
    end
    position_next = (pos_eff >= POS_HUM_CRC) ? POS_TEMP_MSB : (pos_eff + 3'd1);
    crc_step      = crc8_byte(running_crc, byte_in.data_byte);
    frame_done    = byte_take && (pos_eff == POS_HUM_CRC);
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= POS_TEMP_MSB;
      running_crc  <= CRC_INIT;
      temp_ok_hold <= 1'b0;
    end else if (byte_take) begin
      position <= position_next;
      unique case (pos_eff) inside
        POS_TEMP_MSB, POS_HUM_MSB: begin
          running_crc <= crc8_byte(CRC_INIT, byte_in.data_byte);
        end
        POS_TEMP_LSB, POS_HUM_LSB: begin
          running_crc <= crc_step;
        end
        POS_TEMP_CRC: begin
          temp_ok_hold <= (running_crc == byte_in.data_byte);
          running_crc  <= CRC_INIT;
        end
        default: begin
          running_crc <= CRC_INIT;
        end
      endcase
    end
  end

  // word holds, written before they are read within a frame
  always_ff @(posedge clk) begin
    if (byte_take) begin
      unique case (pos_eff) inside
        POS_TEMP_MSB, POS_HUM_MSB: high_hold <= byte_in.data_byte;
        POS_TEMP_LSB:              temp_hold <= {high_hold, byte_in.data_byte};
        POS_HUM_LSB:               low_hold  <= byte_in.data_byte;
        default: begin
        end
      endcase
    end
  end

  // completed frame register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (frame_done) begin
      frame_valid <= 1'b1;
    end else if (frame_pop) begin
      frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_done) begin
      frame.temperature_word   <= temp_hold;
      frame.humidity_word      <= {high_hold, low_hold};
      frame.temperature_crc_ok <= temp_ok_hold;
      frame.humidity_crc_ok    <= (running_crc == byte_in.data_byte);
    end
  end

endmodule

[design/htfd_convert.sv]
// scaling of the raw words to hundredths and the result register
// depends on htfd_pkg; one constant multiply and one correction per word
module htfd_convert
  import htfd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         frame_valid,
  input  frame_t       frame,
  output logic         frame_pop,
  input  logic         result_stall,
  output logic         result_valid,
  output result_item_t result_data
);

  logic [30:0]        temp_prod;
  logic [29:0]        hum_prod;
  logic [15:0]        temp_quot;
  logic [15:0]        hum_quot;
  logic signed [15:0] temp_centi;
  logic               result_free;

  // scale by constant, then divide by the word full scale
  always_comb begin
    temp_prod  = 31'(TEMP_SCALE) * 31'(frame.temperature_word);
    hum_prod   = 30'(HUM_SCALE) * 30'(frame.humidity_word);
    temp_quot  = div_word_full({1'b0, temp_prod});
    hum_quot   = div_word_full({2'b00, hum_prod});
    temp_centi = $signed(temp_quot) + TEMP_OFFSET;
  end

  // the frame moves on whenever the result register is empty or drains
  assign result_free = !result_valid || !result_stall;
  assign frame_pop   = frame_valid && result_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_free) begin
      result_valid <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_pop) begin
      result_data.temperature_centi  <= temp_centi[14:0];
      result_data.humidity_centi     <= hum_quot[13:0];
      result_data.temperature_word   <= frame.temperature_word;
      result_data.humidity_word      <= frame.humidity_word;
      result_data.temperature_crc_ok <= frame.temperature_crc_ok;
      result_data.humidity_crc_ok    <= frame.humidity_crc_ok;
    end
  end

endmodule

[design/humidity_temp_frame_decoder_unit.sv]
// the transfer of the sixth byte loads the frame register, which passes to the result register once it is free
// one byte per cycle while bytes are not stalled; frame register then result register
// bytes stall only while a finished frame waits behind a stalled result
// synchronous reset clears byte position, crc to 0xff and both valid flags
// top level of the humidity/temperature frame decoder
// depends on htfd_pkg, htfd_frame_track and htfd_convert
module humidity_temp_frame_decoder_unit
  import htfd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         byte_valid,
  output logic         byte_stall,
  input  byte_item_t   byte_data,
  output logic         result_valid,
  input  logic         result_stall,
  output result_item_t result_data
);

  logic   byte_take;
  logic   frame_valid;
  logic   frame_pop;
  frame_t frame;

  // input transfer
  assign byte_stall = frame_valid && !frame_pop;
  assign byte_take  = byte_valid && !byte_stall;

  htfd_frame_track u_track (
    .clk        (clk),
    .rst        (rst),
    .byte_take  (byte_take),
    .byte_in    (byte_data),
    .frame_pop  (frame_pop),
    .frame_valid(frame_valid),
    .frame      (frame)
  );

  htfd_convert u_convert (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame       (frame),
    .frame_pop   (frame_pop),
    .result_stall(result_stall),
    .result_valid(result_valid),
    .result_data (result_data)
  );

endmodule

[design/htfd_checker.sv]
// port-level checks of the humidity/temperature frame decoder
// depends on htfd_pkg; bound to humidity_temp_frame_decoder_unit below
module htfd_checker
  import htfd_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         byte_valid,
  input logic         byte_stall,
  input logic         result_valid,
  input logic         result_stall,
  input result_item_t result_data
);

  // a stalled result stays
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result_data))
    else $error("result payload changed while stalled");

  // a new result follows a byte transfer through the frame register and the result register
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(byte_valid && !byte_stall, 2))
    else $error("result appeared without a preceding byte transfer");

  // converted values stay within the sensor ranges
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result_data.temperature_centi >= -15'sd4500) &&
                     (result_data.temperature_centi <= 15'sd13000) &&
                     (result_data.humidity_centi <= 14'd10000))
    else $error("converted value out of range");

endmodule

bind humidity_temp_frame_decoder_unit htfd_checker u_checker (.*);
